// File: rtl/core/usb_control_endpoint_sequencer_assert.svh
// ----------------------------------------------------------------------------
// usb control endpoint sequencer assertion macros
// concurrent assertion shorthands used by the rtl file of the block
// ----------------------------------------------------------------------------
`ifndef USB_CONTROL_ENDPOINT_SEQUENCER_ASSERT_SVH
`define USB_CONTROL_ENDPOINT_SEQUENCER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define UCEP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define UCEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ucep_pkg.sv
// ----------------------------------------------------------------------------
// ucep_pkg
// types and constants of the usb endpoint-zero control sequencer
// ----------------------------------------------------------------------------
package ucep_pkg;

  // default max packet size of endpoint zero
  localparam int unsigned MaxPacketDefault = 64;

  // setup request decoding
  localparam logic [7:0] ReqTypeDirIn    = 8'h80;
  localparam logic [7:0] ReqTypeKindMask = 8'h60;
  localparam logic [7:0] ReqSetAddress   = 8'd5;

  // event kind carried in tuser
  typedef enum logic [1:0] {
    CMD_SETUP    = 2'd0,
    CMD_IN_DONE  = 2'd1,
    CMD_OUT_DONE = 2'd2,
    CMD_IGNORED  = 2'd3
  } cmd_e;

  // control transfer stage
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_WDATA  = 3'd1,
    ST_WSTAT  = 3'd2,
    ST_RDATA  = 3'd3,
    ST_RZLP   = 3'd4,
    ST_RSTAT  = 3'd5,
    ST_STATUS = 3'd6
  } ctrl_state_e;

  // one result word, in_armed in the lowest bit
  typedef struct packed {
    logic [6:0]  device_address;
    logic        address_valid;
    logic        notify_canceled;
    logic        notify_complete;
    logic        prior_aborted;
    logic        stall_res;
    logic        out_toggle;
    logic        out_armed;
    logic        in_toggle;
    logic [6:0]  data_length;
    logic [15:0] data_offset;
    logic        in_armed;
  } result_t;

endpackage

// File: rtl/core/usb_control_endpoint_sequencer.sv
// an accepted word is held in the input register until the result register takes it
// throughput: one word per cycle; with both registers full s_axis_tready follows m_axis_tready
// the result register holds while m_axis_tready is low and the input register still fills
// reset: rst_ni is asynchronous, active low; it clears both valid flags and all
// control state (idle stage, zero lengths, index, pending address and toggles)
// ----------------------------------------------------------------------------
// usb_control_endpoint_sequencer
// endpoint-zero control transfer sequencer: tracks setup, data and status
// stages, arms in/out buffers with toggles, splits reads into max-packet
// chunks and writes the device address after the status stage
// ----------------------------------------------------------------------------
`include "usb_control_endpoint_sequencer_assert.svh"

module usb_control_endpoint_sequencer #(
  parameter int unsigned MAX_PACKET = ucep_pkg::MaxPacketDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // request_type[7:0], request_code[15:8], request_value[31:16],
  // request_length[47:32], response_length[64:48], zero fill [71:65]
  input  logic [71:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // in_armed[0], data_offset[16:1], data_length[23:17], in_toggle[24],
  // out_armed[25], out_toggle[26], stall_res[27], prior_aborted[28],
  // notify_complete[29], notify_canceled[30], address_valid[31],
  // device_address[38:32], zero fill [39]
  output logic [39:0] m_axis_tdata
);

  // max packet size in the widths it is compared at
  localparam logic [6:0]  MaxPkt7  = 7'(MAX_PACKET);
  localparam logic [15:0] MaxPkt16 = 16'(MAX_PACKET);

  // --------------------------------------------------------------------------
  // two-register pipeline: input word register, then result register
  // --------------------------------------------------------------------------
  logic                in_valid_q;
  ucep_pkg::cmd_e      cmd_q;
  logic [64:0]         data_q;
  logic                out_valid_q;
  ucep_pkg::result_t   res_q;
  ucep_pkg::result_t   res_d;
  logic                advance;
  logic                s_accept;

  // the held word moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q  <= ucep_pkg::cmd_e'(s_axis_tuser);
      data_q <= s_axis_tdata[64:0];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

  // --------------------------------------------------------------------------
  // control transfer state
  // --------------------------------------------------------------------------
  ucep_pkg::ctrl_state_e state_q, state_d;
  logic [15:0] length_q, length_d;       // transfer length
  logic [15:0] index_q, index_d;         // bytes of the transfer already moved
  logic [15:0] setup_len_q, setup_len_d; // wLength of the current request
  logic        ns_q, ns_d;               // current request is non-standard
  logic [6:0]  pend_q, pend_d;           // address to write after status
  logic        in_tog_q, in_tog_d;
  logic        out_tog_q, out_tog_d;
  // last read chunk was shorter than a max packet, so the length is no
  // multiple of it; stands in for a modulo of the transfer length
  logic        short_q, short_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ucep_pkg::ST_IDLE;
      length_q    <= '0;
      index_q     <= '0;
      setup_len_q <= '0;
      ns_q        <= 1'b0;
      pend_q      <= '0;
      in_tog_q    <= 1'b0;
      out_tog_q   <= 1'b0;
      short_q     <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      length_q    <= length_d;
      index_q     <= index_d;
      setup_len_q <= setup_len_d;
      ns_q        <= ns_d;
      pend_q      <= pend_d;
      in_tog_q    <= in_tog_d;
      out_tog_q   <= out_tog_d;
      short_q     <= short_d;
    end
  end

  // --------------------------------------------------------------------------
  // setup word decode
  // --------------------------------------------------------------------------
  logic [7:0]  rtype;
  logic [7:0]  rcode;
  logic [15:0] rvalue;
  logic [15:0] rlen;
  logic [16:0] xfer;
  logic        xfer_neg;
  logic [15:0] xfer_lo;
  logic        is_setup;
  logic        stall_req;
  logic        xfer_pos;
  logic        rlen_nz;
  logic        ns_new;
  logic        dir_in;

  assign rtype    = data_q[7:0];
  assign rcode    = data_q[15:8];
  assign rvalue   = data_q[31:16];
  assign rlen     = data_q[47:32];
  assign xfer     = data_q[64:48];
  assign xfer_neg = xfer[16];
  assign xfer_lo  = xfer[15:0];
  assign is_setup = (cmd_q == ucep_pkg::CMD_SETUP);

  // request error: negative length or more than the host allows
  assign stall_req = xfer_neg || (xfer_lo > rlen);
  assign xfer_pos  = !xfer_neg && (xfer_lo != 16'd0);
  assign rlen_nz   = (rlen != 16'd0);
  assign ns_new    = ((rtype & ucep_pkg::ReqTypeKindMask) != 8'h00);
  assign dir_in    = ((rtype & ucep_pkg::ReqTypeDirIn) != 8'h00);

  // --------------------------------------------------------------------------
  // chunking of the data stage, shared by setup, in and out events
  // on a setup the transfer starts fresh from the decoded length
  // --------------------------------------------------------------------------
  logic [15:0] rs_len;
  logic [15:0] rs_idx;
  logic [15:0] rs_setup;
  logic        rs_mod0;
  logic [15:0] remain;
  logic [6:0]  txlen;
  logic [15:0] idx_next;
  logic        chunk;
  logic        zlp;
  logic        ns_eff;
  ucep_pkg::ctrl_state_e rs_next;

  assign rs_len   = is_setup ? xfer_lo : length_q;
  assign rs_idx   = is_setup ? 16'd0 : index_q;
  assign rs_setup = is_setup ? rlen : setup_len_q;
  // a fresh transfer only reaches the zero-length check with length zero
  assign rs_mod0  = is_setup ? 1'b1 : !short_q;
  assign ns_eff   = is_setup ? ns_new : ns_q;

  assign remain   = rs_len - rs_idx;
  assign txlen    = (remain < MaxPkt16) ? remain[6:0] : MaxPkt7;
  assign idx_next = rs_idx + {9'd0, txlen};
  assign chunk    = (txlen != 7'd0);
  // host asked for more than we send and the last packet was full size
  assign zlp      = !chunk && (rs_setup > rs_len) && rs_mod0;
  assign rs_next  = chunk ? ucep_pkg::ST_RDATA :
                    (zlp ? ucep_pkg::ST_RZLP : ucep_pkg::ST_RSTAT);

  // toggle values before any arm of this event; setup_ok restarts in, and out if rlen_nz
  logic setup_ok;
  logic in_tog_base;
  logic out_tog_base;
  logic arm_in;
  logic arm_out;

  assign setup_ok     = is_setup && !stall_req;
  assign in_tog_base  = setup_ok ? 1'b1 : in_tog_q;
  assign out_tog_base = (setup_ok && rlen_nz) ? 1'b1 : out_tog_q;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    length_d    = length_q;
    index_d     = index_q;
    setup_len_d = setup_len_q;
    ns_d        = ns_q;
    pend_d      = pend_q;
    short_d     = short_q;
    in_tog_d    = arm_in ? ~in_tog_base : in_tog_base;
    out_tog_d   = arm_out ? ~out_tog_base : out_tog_base;

    case (cmd_q)
      ucep_pkg::CMD_SETUP: begin
        state_d     = ucep_pkg::ST_IDLE;
        ns_d        = ns_new;
        setup_len_d = rlen;
        // set address latches even when the request stalls
        if (!ns_new && (rcode == ucep_pkg::ReqSetAddress)) begin
          pend_d = rvalue[6:0];
        end
        if (rlen_nz) begin
          length_d = xfer_lo;
          index_d  = 16'd0;
          if (!stall_req) begin
            if (dir_in) begin
              state_d = rs_next;
              if (chunk) begin
                index_d = idx_next;
                short_d = (txlen != MaxPkt7);
              end
            end else begin
              state_d = ucep_pkg::ST_WDATA;
            end
          end
        end else begin
          state_d = ucep_pkg::ST_STATUS;
        end
        if (stall_req) begin
          state_d = ucep_pkg::ST_IDLE;
        end
      end
      ucep_pkg::CMD_IN_DONE: begin
        case (state_q)
          ucep_pkg::ST_RDATA: begin
            state_d = rs_next;
            if (chunk) begin
              index_d = idx_next;
              short_d = (txlen != MaxPkt7);
            end
          end
          ucep_pkg::ST_RZLP:   state_d = ucep_pkg::ST_RSTAT;
          ucep_pkg::ST_WSTAT:  state_d = ucep_pkg::ST_IDLE;
          ucep_pkg::ST_STATUS: begin
            state_d = ucep_pkg::ST_IDLE;
            pend_d  = 7'd0;
          end
          default: ;
        endcase
      end
      ucep_pkg::CMD_OUT_DONE: begin
        case (state_q)
          ucep_pkg::ST_WDATA: begin
            index_d = idx_next;
            if (idx_next >= length_q) begin
              state_d = ucep_pkg::ST_WSTAT;
            end
          end
          default: state_d = ucep_pkg::ST_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // result word
  // --------------------------------------------------------------------------
  always_comb begin
    res_d   = '0;
    arm_in  = 1'b0;
    arm_out = 1'b0;

    case (cmd_q)
      ucep_pkg::CMD_SETUP: begin
        arm_out = 1'b1;
        // cancel of the previous request shows here only
        res_d.prior_aborted = ((state_q == ucep_pkg::ST_WDATA) ||
                               (state_q == ucep_pkg::ST_RDATA)) && ns_q;
        if (rlen_nz && !stall_req && dir_in) begin
          if (chunk) begin
            arm_in            = 1'b1;
            res_d.data_offset = rs_idx;
            res_d.data_length = txlen;
          end else begin
            arm_in                = zlp;
            res_d.notify_complete = ns_eff;
          end
        end
        if (!rlen_nz && !stall_req) begin
          arm_in = 1'b1;
        end
        if (stall_req) begin
          res_d.stall_res = 1'b1;
          if (xfer_pos && ns_new) begin
            res_d.notify_complete = 1'b1;
            res_d.notify_canceled = 1'b1;
          end
        end
      end
      ucep_pkg::CMD_IN_DONE: begin
        case (state_q)
          ucep_pkg::ST_RDATA: begin
            if (chunk) begin
              arm_in            = 1'b1;
              res_d.data_offset = rs_idx;
              res_d.data_length = txlen;
            end else begin
              arm_in                = zlp;
              res_d.notify_complete = ns_eff;
            end
          end
          ucep_pkg::ST_RZLP, ucep_pkg::ST_WSTAT: ;
          ucep_pkg::ST_STATUS: begin
            // address zero is never written
            if (pend_q != 7'd0) begin
              res_d.address_valid  = 1'b1;
              res_d.device_address = pend_q;
            end
          end
          default: res_d.stall_res = 1'b1;
        endcase
      end
      ucep_pkg::CMD_OUT_DONE: begin
        arm_out = 1'b1;
        case (state_q)
          ucep_pkg::ST_WDATA: begin
            res_d.data_offset = index_q;
            // last chunk in: arm the zero-length status packet
            if (idx_next >= length_q) begin
              arm_in                = 1'b1;
              res_d.data_offset     = 16'd0;
              res_d.notify_complete = ns_q;
            end
          end
          ucep_pkg::ST_RDATA: begin
            // host cut the read short
            res_d.notify_complete = ns_q;
            res_d.notify_canceled = ns_q;
          end
          ucep_pkg::ST_RSTAT: ;
          default: res_d.stall_res = 1'b1;
        endcase
      end
      default: ;
    endcase

    res_d.in_armed   = arm_in;
    res_d.in_toggle  = arm_in && in_tog_base;
    res_d.out_armed  = arm_out;
    res_d.out_toggle = arm_out && out_tog_base;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `UCEP_ASSERT_IMPLIES(a_stall_no_in_arm, clk_i, rst_ni,
    m_axis_tvalid && res_q.stall_res, !res_q.in_armed,
    "stalled result also arms an in packet")
  `UCEP_ASSERT_IMPLIES(a_len_max_packet, clk_i, rst_ni,
    m_axis_tvalid, res_q.data_length <= MaxPkt7,
    "armed packet longer than max packet")
  `UCEP_ASSERT_IMPLIES(a_cancel_needs_complete, clk_i, rst_ni,
    m_axis_tvalid && res_q.notify_canceled, res_q.notify_complete,
    "cancel notice without complete notice")
  `UCEP_ASSERT_IMPLIES(a_ready_when_drained, clk_i, rst_ni,
    !out_valid_q, s_axis_tready,
    "input stalled while result register is empty")
  `UCEP_ASSERT_NEXT(a_word_moves_on, clk_i, rst_ni,
    in_valid_q && !out_valid_q, m_axis_tvalid,
    "held word did not reach the result register")

endmodule
